// ===== hw/rtl/utf8_stream_validator_defines.svh =====
// Assertion macros used by the checker file of the UTF-8 stream validator.
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define UTF8V_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define UTF8V_ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/utf8v_pkg.sv =====
// Package with the error codes, state and result types of the UTF-8 validator.
package utf8v_pkg;

  localparam int unsigned ErrW   = 3;
  localparam int unsigned AccumW = 31;

  localparam logic [ErrW-1:0] ERR_NONE      = 3'd0;
  localparam logic [ErrW-1:0] ERR_BAD_LEAD  = 3'd1;
  localparam logic [ErrW-1:0] ERR_OVERLONG  = 3'd2;
  localparam logic [ErrW-1:0] ERR_BAD_CONT  = 3'd3;
  localparam logic [ErrW-1:0] ERR_SURROGATE = 3'd4;
  localparam logic [ErrW-1:0] ERR_RANGE     = 3'd5;

  localparam logic [AccumW-1:0] MAX_CODEPOINT = 31'h0010_FFFF;
  // Upper bits of a surrogate codepoint, i.e. codepoint[30:11] for 0xD800-0xDFFF.
  localparam logic [19:0]       SURR_HI       = 20'h0001B;

  typedef struct packed {
    logic [2:0]        pending_count;
    logic [7:0]        lead_byte;
    logic [AccumW-1:0] code_accum;
    logic [ErrW-1:0]   error_code;
    logic              stopped;
  } state_t;

  typedef struct packed {
    logic            valid_so_far;
    logic [ErrW-1:0] error_kind;
    logic            final_res;
  } result_t;

endpackage

// ===== hw/rtl/utf8v_in_if.sv =====
// Byte input channel of the UTF-8 validator.
interface utf8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

// ===== hw/rtl/utf8v_out_if.sv =====
// Result channel of the UTF-8 validator.
interface utf8v_out_if;
  logic       valid;
  logic       ready;
  logic       valid_so_far;
  logic [2:0] error_kind;
  logic       final_res;

  modport source (output valid, output valid_so_far, output error_kind, output final_res,
                  input ready);
  modport sink   (input valid, input valid_so_far, input error_kind, input final_res,
                  output ready);
endinterface

// ===== hw/rtl/utf8v_step.sv =====
// Per-byte decode step: next checker state and the result for one byte.
module utf8v_step (
  input  logic [7:0]       data_byte,
  input  logic             is_last,
  input  utf8v_pkg::state_t cur,
  output utf8v_pkg::state_t nxt,
  output utf8v_pkg::result_t res
);

  utf8v_pkg::state_t              upd;
  logic                           overlong;
  logic [utf8v_pkg::AccumW-1:0]   accum_sh;
  logic [2:0]                     pend_dec;

  assign accum_sh = {cur.code_accum[utf8v_pkg::AccumW-7:0], data_byte[5:0]};
  assign pend_dec = cur.pending_count - 3'd1;

  // The first continuation byte of a longer form must lift the value past
  // what a shorter form could hold.
  assign overlong =
      (cur.lead_byte == 8'hE0 && cur.pending_count == 3'd2 && data_byte < 8'hA0) ||
      (cur.lead_byte == 8'hF0 && cur.pending_count == 3'd3 && data_byte < 8'h90) ||
      (cur.lead_byte == 8'hF8 && cur.pending_count == 3'd4 && data_byte < 8'h88) ||
      (cur.lead_byte == 8'hFC && cur.pending_count == 3'd5 && data_byte < 8'h84);

  always_comb begin
    upd = cur;
    if (!cur.stopped && cur.error_code == utf8v_pkg::ERR_NONE) begin
      if (data_byte == 8'h00) begin
        upd.stopped = 1'b1;
      end else if (cur.pending_count == 3'd0) begin
        upd.lead_byte = data_byte;
        priority if (!data_byte[7]) begin
          upd.pending_count = 3'd0;
          upd.code_accum    = '0;
        end else if (data_byte[7:5] == 3'b110) begin
          upd.pending_count = 3'd1;
          upd.code_accum    = {26'd0, data_byte[4:0]};
          if (data_byte[4:1] == 4'd0) begin
            upd.error_code = utf8v_pkg::ERR_OVERLONG;
          end
        end else if (data_byte[7:4] == 4'b1110) begin
          upd.pending_count = 3'd2;
          upd.code_accum    = {27'd0, data_byte[3:0]};
        end else if (data_byte[7:3] == 5'b11110) begin
          upd.pending_count = 3'd3;
          upd.code_accum    = {28'd0, data_byte[2:0]};
        end else if (data_byte[7:2] == 6'b111110) begin
          upd.pending_count = 3'd4;
          upd.code_accum    = {29'd0, data_byte[1:0]};
        end else if (data_byte[7:1] == 7'b1111110) begin
          upd.pending_count = 3'd5;
          upd.code_accum    = {30'd0, data_byte[0]};
        end else begin
          upd.pending_count = 3'd0;
          upd.error_code    = utf8v_pkg::ERR_BAD_LEAD;
        end
      end else begin
        priority if (overlong) begin
          upd.error_code = utf8v_pkg::ERR_OVERLONG;
        end else if (data_byte[7:6] != 2'b10) begin
          upd.error_code = utf8v_pkg::ERR_BAD_CONT;
        end else begin
          upd.code_accum    = accum_sh;
          upd.pending_count = pend_dec;
          if (pend_dec == 3'd0) begin
            if (accum_sh[utf8v_pkg::AccumW-1:11] == utf8v_pkg::SURR_HI) begin
              upd.error_code = utf8v_pkg::ERR_SURROGATE;
            end else if (accum_sh > utf8v_pkg::MAX_CODEPOINT) begin
              upd.error_code = utf8v_pkg::ERR_RANGE;
            end
          end
        end
      end
    end
  end

  always_comb begin
    res.valid_so_far = (upd.error_code == utf8v_pkg::ERR_NONE);
    res.error_kind   = upd.error_code;
    res.final_res    = is_last;
    // The buffer ends here, so the next byte starts from a clean state.
    nxt = is_last ? '0 : upd;
  end

endmodule

// ===== hw/rtl/utf8_stream_validator.sv =====
// Top level of the streaming UTF-8 validator: input register, decode step, result register.
//
// Usage: bytes of a buffer enter on in_ch, one per transaction, with is_last
// set on the final byte. Every input transaction yields exactly one result
// transaction on out_ch carrying valid_so_far (no error seen yet in this
// buffer), error_kind (the first failure, sticky until the end of the buffer)
// and final_res (a copy of is_last).
// Timing: an accepted byte passes through two register stages (input register,
// result register) before its result shows on out_ch.
// Throughput: one byte per clock while out_ch accepts results; the single
// decode step between the two registers reads the checker state written by
// the previous byte, so consecutive bytes never wait on each other.
// Stalls: when out_ch is held off, the result register keeps its transaction
// and the input register can still take one more byte; in_ch.ready drops only
// when both stages are full.
// Reset: rst_n is synchronous and active low; it empties both stages and
// returns the checker state to "no sequence open, no error, not stopped".
// State also clears by itself after each byte flagged is_last.
module utf8_stream_validator (
  input  logic          clk,
  input  logic          rst_n,
  utf8v_in_if.sink      in_ch,
  utf8v_out_if.source   out_ch
);

  // Input register stage.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Checker state and result register.
  utf8v_pkg::state_t  state_r;
  utf8v_pkg::state_t  state_nxt;
  utf8v_pkg::result_t res_nxt;
  utf8v_pkg::result_t res_r;
  logic               out_valid_r;

  logic advance;

  // The result register may load whenever it is empty or being drained.
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;

  utf8v_step u_step (
    .data_byte (s1_byte_r),
    .is_last   (s1_last_r),
    .cur       (state_r),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        // The state moves only when a byte really passes the decode step.
        if (s1_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.is_last;
    end
    if (advance && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.valid_so_far = res_r.valid_so_far;
  assign out_ch.error_kind   = res_r.error_kind;
  assign out_ch.final_res    = res_r.final_res;

endmodule

// ===== hw/rtl/utf8v_checker.sv =====
// Port-level assertions for the UTF-8 validator and the bind that attaches them.
`include "utf8_stream_validator_defines.svh"

module utf8v_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_valid_so_far,
  input logic [2:0] out_error_kind,
  input logic       out_final_res
);

  // A stalled result holds its payload.
  `UTF8V_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable({out_valid_so_far, out_error_kind, out_final_res}), "result changed while stalled")

  // The verdict flag agrees with the error code.
  `UTF8V_ASSERT_CLK(a_verdict, out_valid |-> (out_valid_so_far == (out_error_kind == utf8v_pkg::ERR_NONE)), "verdict disagrees with error code")

  // Within a buffer an error, once reported, stays the same on the next result.
  `UTF8V_ASSERT_CLK(a_sticky, (out_valid && out_ready && !out_final_res && out_error_kind != utf8v_pkg::ERR_NONE) ##1 (out_valid && out_ready) |-> out_error_kind == $past(out_error_kind), "sticky error code changed")

  // Reset empties the result stage.
  `UTF8V_ASSERT_CLK_ALWAYS(a_reset_empty, $past(!rst_n) |-> !out_valid, "result valid right after reset")

endmodule

bind utf8_stream_validator utf8v_checker u_utf8v_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_valid_so_far (out_ch.valid_so_far),
  .out_error_kind   (out_ch.error_kind),
  .out_final_res    (out_ch.final_res)
);
